FILE: rtl/sidr_pkg.sv
// Shared types, constants and helpers for the signed integer to radix text unit.
package sidr_pkg;

    localparam int NUM_SLOTS     = 16;
    localparam int CHARS_W       = NUM_SLOTS * 8;
    localparam int DIV_STEP_BITS = 8;
    localparam int PADDR_W       = 5;
    localparam int PDATA_W       = 64;

    localparam logic [7:0] PLUS_CHAR  = 8'h2B;
    localparam logic [7:0] MINUS_CHAR = 8'h2D;

    localparam logic [1:0] REG_DIGIT_COUNT = 2'd0;
    localparam logic [1:0] REG_CHARS_LOW   = 2'd1;
    localparam logic [1:0] REG_CHARS_HIGH  = 2'd2;

    localparam logic [4:0] DIGIT_COUNT_RESET = 5'd10;

    // Classification of one item, passed from the front to the back.
    typedef struct packed {
        logic base_invalid;
        logic neg;
    } sidr_cls_t;

    // Character for digit value k from the packed digit set.
    function automatic logic [7:0] char_of(input logic [CHARS_W-1:0] chars,
                                           input logic [3:0] k);
        return chars[{k, 3'b000} +: 8];
    endfunction

endpackage

FILE: rtl/sidr_if.sv
// Stream interfaces for the value input and the text output.
interface sidr_value_if #(parameter int WIDTH = 32);
    logic              valid;
    logic              ready;
    logic signed [WIDTH-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface sidr_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last;
    logic       base_invalid;

    modport source (output valid, output char_code, output last, output base_invalid,
                    input ready);
    modport sink   (input valid, input char_code, input last, input base_invalid,
                    output ready);
endinterface

FILE: rtl/sidr_front.sv
// Front end: accepts values, checks the digit set, forms sign and magnitude.
module sidr_front
    import sidr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_RADIX   = 16
)
(
    sidr_value_if.sink             value_ch,
    input  logic [4:0]             digit_count,
    input  logic [CHARS_W-1:0]     digit_chars,
    input  logic                   q_full,
    output logic                   push,
    output sidr_cls_t              cls,
    output logic [VALUE_WIDTH-1:0] mag
);

    logic [VALUE_WIDTH-1:0] vu;
    logic                   bad;
    logic [7:0]             ci;

    assign value_ch.ready = !q_full;
    assign push           = value_ch.valid && !q_full;

    assign vu = value_ch.value;

    // Digit set check: count in range, no zero/sign bytes, no repeats
    always_comb
    begin
        bad = (digit_count < 5'd2) || (digit_count > 5'(MAX_RADIX));
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            ci = char_of(digit_chars, 4'(i));
            if (5'(i) < digit_count)
            begin
                if (ci == 8'd0 || ci == PLUS_CHAR || ci == MINUS_CHAR)
                begin
                    bad = 1'b1;
                end
                for (int j = i + 1; j < NUM_SLOTS; j++)
                begin
                    if (5'(j) < digit_count && char_of(digit_chars, 4'(j)) == ci)
                    begin
                        bad = 1'b1;
                    end
                end
            end
        end
    end

    assign cls.base_invalid = bad;
    assign cls.neg          = vu[VALUE_WIDTH-1];

    // Two's complement negate; the most negative value comes out as 2^(W-1) unsigned
    assign mag = vu[VALUE_WIDTH-1] ? (~vu + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : vu;

endmodule

FILE: rtl/sidr_queue.sv
// Two-entry queue between the front and the back.
module sidr_queue
    import sidr_pkg::*;
#(
    parameter int MAG_W = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sidr_cls_t        push_cls,
    input  logic [MAG_W-1:0] push_mag,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output sidr_cls_t        pop_cls,
    output logic [MAG_W-1:0] pop_mag
);

    sidr_cls_t        ent_cls_reg [2];
    logic [MAG_W-1:0] ent_mag_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign pop_cls   = ent_cls_reg[rd_ptr_reg];
    assign pop_mag   = ent_mag_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_cls_reg[wr_ptr_reg] <= push_cls;
            ent_mag_reg[wr_ptr_reg] <= push_mag;
        end
    end

endmodule

FILE: rtl/sidr_back.sv
// Back end: digit extraction by repeated division, then character emission.
module sidr_back
    import sidr_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [4:0]             digit_count,
    input  logic [CHARS_W-1:0]     digit_chars,
    input  logic                   q_valid,
    input  sidr_cls_t              q_cls,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    output logic                   q_pop,
    sidr_text_if.source            text_ch
);

    localparam int STEP    = DIV_STEP_BITS;
    localparam int NSTEP   = (VALUE_WIDTH + STEP - 1) / STEP;
    localparam int MAG_W   = NSTEP * STEP;
    localparam int STEP_CW = $clog2(NSTEP + 1);
    localparam int IDX_W   = $clog2(VALUE_WIDTH);
    localparam int CNT_W   = $clog2(VALUE_WIDTH + 1);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_SIGN = 6'b000100,
        ST_RD   = 6'b001000,
        ST_WR   = 6'b010000,
        ST_BAD  = 6'b100000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [MAG_W-1:0]   mag_reg;
    logic [MAG_W-1:0]   mag_next;
    logic [3:0]         rem_reg;
    logic [3:0]         rem_next;
    logic [STEP_CW-1:0] step_reg;
    logic [STEP_CW-1:0] step_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   idx_next;
    logic               neg_reg;
    logic               neg_next;
    logic [3:0]         rd_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [7:0]         char_reg;
    logic               last_reg;
    logic               inv_reg;

    logic [3:0]         dig_mem [VALUE_WIDTH];

    logic [STEP-1:0]    chunk;
    logic [STEP-1:0]    q_bits;
    logic [4:0]         t;
    logic [3:0]         r;
    logic [3:0]         rem_new;
    logic [MAG_W-1:0]   quo;
    logic               last_step;
    logic               slot_free;
    logic               mem_we;
    logic               out_load;
    logic [7:0]         out_char;
    logic               out_last;
    logic               out_inv;

    // One chunk of restoring long division per cycle; quotient bits shift in at the bottom
    always_comb
    begin
        chunk  = mag_reg[MAG_W-1 -: STEP];
        r      = rem_reg;
        q_bits = '0;
        t      = '0;
        for (int b = STEP - 1; b >= 0; b--)
        begin
            t = {r, chunk[b]};
            if (t >= digit_count)
            begin
                t         = t - digit_count;
                q_bits[b] = 1'b1;
            end
            r = t[3:0];
        end
        rem_new = r;
        quo     = (mag_reg << STEP) | MAG_W'(q_bits);
    end

    assign last_step = step_reg == STEP_CW'(NSTEP - 1);
    assign slot_free = !out_valid_reg || text_ch.ready;

    always_comb
    begin
        state_next = state_reg;
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        neg_next   = neg_reg;
        q_pop      = 1'b0;
        mem_we     = 1'b0;
        out_load   = 1'b0;
        out_char   = '0;
        out_last   = 1'b0;
        out_inv    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    neg_next = q_cls.neg;
                    if (q_cls.base_invalid)
                    begin
                        state_next = ST_BAD;
                    end
                    else
                    begin
                        mag_next   = MAG_W'(q_mag);
                        rem_next   = '0;
                        step_next  = '0;
                        cnt_next   = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                mag_next  = quo;
                rem_next  = rem_new;
                step_next = step_reg + STEP_CW'(1);
                if (last_step)
                begin
                    mem_we    = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    rem_next  = '0;
                    step_next = '0;
                    if (quo == '0)
                    begin
                        idx_next   = cnt_reg[IDX_W-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_RD;
                    end
                end
            end
            ST_SIGN:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_char   = MINUS_CHAR;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_WR;
            end
            ST_WR:
            begin
                if (slot_free)
                begin
                    out_load = 1'b1;
                    out_char = char_of(digit_chars, rd_reg);
                    out_last = idx_reg == '0;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_BAD:
            begin
                if (slot_free)
                begin
                    out_load   = 1'b1;
                    out_last   = 1'b1;
                    out_inv    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !text_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        if (out_load)
        begin
            char_reg <= out_char;
            last_reg <= out_last;
            inv_reg  <= out_inv;
        end
    end

    // Digit store, least significant digit first
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            dig_mem[cnt_reg[IDX_W-1:0]] <= rem_new;
        end
        if (state_reg == ST_RD)
        begin
            rd_reg <= dig_mem[idx_reg];
        end
    end

    assign text_ch.valid        = out_valid_reg;
    assign text_ch.char_code    = char_reg;
    assign text_ch.last         = last_reg;
    assign text_ch.base_invalid = inv_reg;

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == ST_IDLE)
        else $error("queue popped outside idle");

    a_rem_below_radix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> {1'b0, rem_reg} < digit_count)
        else $error("partial remainder not below radix");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_WR |-> CNT_W'(idx_reg) < cnt_reg)
        else $error("emit index beyond digits made");

endmodule

FILE: rtl/signed_integer_to_radix_digits_unit.sv
// Top level of the signed integer to radix text unit.
// A signed VALUE_WIDTH-bit value goes in; its text comes out one character
// per item: '-' for a negative value, then the digits most significant first,
// with last set on the final character. The radix is digit_count and the digit
// characters come from digit_chars_low/high (APB, 64-bit registers at 0x00,
// 0x08, 0x10). If the digit set is bad (count below 2 or above MAX_RADIX, a
// zero, '+' or '-' byte, or a repeated character) the item yields a single
// result with char_code 0, last 1 and base_invalid 1. Each digit is produced
// by a long division over the whole magnitude that handles 8 magnitude bits
// per cycle; each digit character is then read through the digit store's
// registered read port in state RD and loaded into the output register in
// state WR, which waits while the output register still holds a character
// that has not been accepted. A two-entry queue lets the front take new
// values while the back is busy.
module signed_integer_to_radix_digits_unit
    import sidr_pkg::*;
#(
    parameter int MAX_RADIX   = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    sidr_value_if.sink         value_ch,
    sidr_text_if.source        text_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [4:0]             digit_count_reg;
    logic [63:0]            chars_low_reg;
    logic [63:0]            chars_high_reg;
    logic [CHARS_W-1:0]     digit_chars;
    logic [1:0]             reg_idx;
    logic                   wr_en;

    logic                   push;
    sidr_cls_t              push_cls;
    logic [VALUE_WIDTH-1:0] push_mag;
    logic                   q_full;
    logic                   q_pop;
    logic                   q_valid;
    sidr_cls_t              q_cls;
    logic [VALUE_WIDTH-1:0] q_mag;

    // Register file: 64-bit registers on an 8-byte stride
    assign reg_idx     = paddr[4:3];
    assign pready      = 1'b1;
    assign wr_en       = psel && penable && pwrite;
    assign digit_chars = {chars_high_reg, chars_low_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_count_reg <= DIGIT_COUNT_RESET;
            chars_low_reg   <= '0;
            chars_high_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DIGIT_COUNT: digit_count_reg <= pwdata[4:0];
                REG_CHARS_LOW:   chars_low_reg   <= pwdata;
                REG_CHARS_HIGH:  chars_high_reg  <= pwdata;
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_DIGIT_COUNT: prdata = {59'd0, digit_count_reg};
            REG_CHARS_LOW:   prdata = chars_low_reg;
            REG_CHARS_HIGH:  prdata = chars_high_reg;
            default:         prdata = '0;
        endcase
    end

    // Front: digit set check and sign/magnitude split at acceptance
    sidr_front #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_RADIX   (MAX_RADIX)
    ) u_front (
        .value_ch    (value_ch),
        .digit_count (digit_count_reg),
        .digit_chars (digit_chars),
        .q_full      (q_full),
        .push        (push),
        .cls         (push_cls),
        .mag         (push_mag)
    );

    sidr_queue #(
        .MAG_W (VALUE_WIDTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cls  (push_cls),
        .push_mag  (push_mag),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_cls   (q_cls),
        .pop_mag   (q_mag)
    );

    // Back: division into digits, then sign and digit characters out
    sidr_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .digit_count (digit_count_reg),
        .digit_chars (digit_chars),
        .q_valid     (q_valid),
        .q_cls       (q_cls),
        .q_mag       (q_mag),
        .q_pop       (q_pop),
        .text_ch     (text_ch)
    );

endmodule
